// File: rtl/core/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared widths, command codes, character codes and types of the text console
// writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

   localparam int CMD_W      = 2;
   localparam int CHAR_W     = 8;
   localparam int INDEX_W    = 11;
   localparam int CURSOR_W   = 12;
   localparam int ATTR_W     = 8;
   localparam int SCROLL_W   = 5;
   localparam int CELL_W     = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;
   localparam int RANGE_W    = 14;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUT   = 2'd0,
      CMD_CLEAR = 2'd1,
      CMD_READ  = 2'd2
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ATTRIBUTE   = 1'b0,
      REG_SCROLL_ROWS = 1'b1
   } reg_index_type;

   localparam logic [CHAR_W-1:0]   CH_SPACE     = 8'h20;
   localparam logic [CHAR_W-1:0]   CH_TILDE     = 8'h7E;
   localparam logic [CHAR_W-1:0]   CH_BS        = 8'h08;
   localparam logic [CHAR_W-1:0]   CH_TAB       = 8'h09;
   localparam logic [CHAR_W-1:0]   CH_CR        = 8'h0D;
   localparam logic [CHAR_W-1:0]   CH_LF        = 8'h0A;
   localparam logic [ATTR_W-1:0]   RESET_ATTR   = 8'h07;
   localparam logic [SCROLL_W-1:0] RESET_SCROLL = 5'd25;
   localparam int                  TAB_STEP     = 4;

   typedef struct packed {
      logic [CURSOR_W-1:0] cursor_position;
      logic [CHAR_W-1:0]   read_char;
      logic [ATTR_W-1:0]   read_attr;
   } rsp_type;

endpackage

// File: rtl/core/tcw_if.sv
// ----------------------------------------------------------------------------
// tcw channel interfaces
// Request, response and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tcw_req_if import tcw_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   cmd;
   logic [CHAR_W-1:0]  char_code;
   logic [INDEX_W-1:0] cell_index;

   modport source (output valid, output cmd, output char_code, output cell_index,
                   input ready);
   modport sink   (input valid, input cmd, input char_code, input cell_index,
                   output ready);
endinterface

interface tcw_rsp_if import tcw_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CURSOR_W-1:0] cursor_position;
   logic [CHAR_W-1:0]   read_char;
   logic [ATTR_W-1:0]   read_attr;

   modport source (output valid, output cursor_position, output read_char,
                   output read_attr, input ready);
   modport sink   (input valid, input cursor_position, input read_char,
                   input read_attr, output ready);
endinterface

interface tcw_csr_if import tcw_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// Text console character store with cursor, scroll region and cell read-back.
//
//   port     dir   payload                                   role
//   req_if   in    cmd, char_code, cell_index                request
//   rsp_if   out   cursor_position, read_char, read_attr     one per request
//   csr_if   in    index, data                               register write
//
// A put-character request steps through ST_CHECK, ST_ADDR, ST_EXEC and ST_DONE, with
// ST_BS for a backspace within a row; a scroll first copies the region up one row and
// fills its last row (only the fill for a one-row region), lim being scroll_rows held
// to 1..ROWS. A clear fills every cell, a read fetches one cell. After reset a clearing
// pass over all ROWS*COLUMNS cells (2000 by default) fills the store first. A result
// waits in the output register while the next request is accepted.
// ----------------------------------------------------------------------------
module text_console_writer import tcw_pkg::*; #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic      clock,
   input  logic      reset,
   tcw_req_if.sink   req_if,
   tcw_rsp_if.source rsp_if,
   tcw_csr_if.sink   csr_if
);

   localparam int CELLS = ROWS * COLUMNS;
   localparam int AW    = $clog2(CELLS);

   logic [ATTR_W-1:0]   attr_ff, attr_in;
   logic [SCROLL_W-1:0] scroll_ff, scroll_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic                out_free;
   logic                res_valid;
   rsp_type             res;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [CELL_W-1:0]   wr_data;
   logic                rd_en;
   logic [AW-1:0]       rd_addr;
   logic [CELL_W-1:0]   rd_data;

   tcw_sequencer #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS),
      .AW      (AW)
   ) u_sequencer (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .attr        (attr_ff),
      .scroll_rows (scroll_ff),
      .out_free    (out_free),
      .res_valid   (res_valid),
      .res         (res),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data)
   );

   tcw_text_mem #(
      .DEPTH (CELLS),
      .AW    (AW)
   ) u_text_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // register writes
   assign csr_if.ready = 1'b1;

   always_comb begin
      attr_in   = attr_ff;
      scroll_in = scroll_ff;
      if (csr_if.valid) begin
         unique case (reg_index_type'(csr_if.index))
            REG_ATTRIBUTE:   attr_in   = csr_if.data;
            REG_SCROLL_ROWS: scroll_in = csr_if.data[SCROLL_W-1:0];
            default: ;
         endcase
      end
   end

   // output register
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_free) begin
         rsp_valid_in = res_valid;
         rsp_data_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff      <= RESET_ATTR;
         scroll_ff    <= RESET_SCROLL;
         rsp_valid_ff <= 1'b0;
      end else begin
         attr_ff      <= attr_in;
         scroll_ff    <= scroll_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.cursor_position = rsp_data_ff.cursor_position;
   assign rsp_if.read_char       = rsp_data_ff.read_char;
   assign rsp_if.read_attr       = rsp_data_ff.read_attr;

endmodule

// File: rtl/core/tcw_text_mem.sv
// ----------------------------------------------------------------------------
// tcw_text_mem
// Character store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tcw_text_mem import tcw_pkg::*; #(
   parameter int DEPTH = 2000,
   parameter int AW    = 11
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [CELL_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [CELL_W-1:0] rd_data
);

   logic [CELL_W-1:0] store_ff [DEPTH];
   logic [CELL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/tcw_sequencer.sv
// ----------------------------------------------------------------------------
// tcw_sequencer
// Cursor state and command sequencer: read-modify-write of the character
// store, scroll copy, fill sweeps and the power-up clearing pass.
// ----------------------------------------------------------------------------
module tcw_sequencer import tcw_pkg::*; #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25,
   parameter int AW      = 11
) (
   input  logic                clock,
   input  logic                reset,
   tcw_req_if.sink             req_if,
   input  logic [ATTR_W-1:0]   attr,
   input  logic [SCROLL_W-1:0] scroll_rows,
   input  logic                out_free,
   output logic                res_valid,
   output rsp_type             res,
   output logic                wr_en,
   output logic [AW-1:0]       wr_addr,
   output logic [CELL_W-1:0]   wr_data,
   output logic                rd_en,
   output logic [AW-1:0]       rd_addr,
   input  logic [CELL_W-1:0]   rd_data
);

   localparam int CELLS = ROWS * COLUMNS;
   localparam int CW    = $clog2(COLUMNS);
   localparam int RW    = $clog2(ROWS + 1);
   localparam int PW    = AW + 1;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_CHECK,
      ST_COPY,
      ST_FILL,
      ST_ADDR,
      ST_EXEC,
      ST_BS,
      ST_READ,
      ST_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [RW-1:0]      row_ff, row_in;
   logic [CW-1:0]      col_ff, col_in;
   cmd_type            cmd_ff, cmd_in;
   logic [CHAR_W-1:0]  code_ff, code_in;
   logic [INDEX_W-1:0] idx_ff, idx_in;
   logic               in_range_ff, in_range_in;
   logic [PW-1:0]      ptr_ff, ptr_in;
   logic [PW-1:0]      end_ff, end_in;
   logic               pend_ff, pend_in;
   logic [AW-1:0]      at_ff, at_in;

   logic [5:0]         lim_raw;
   logic [RW-1:0]      lim;
   logic [CW:0]        tab_sum;
   logic [RW-1:0]      shown;
   logic [PW-1:0]      pos;

   // scroll limit clamped to 1..ROWS
   always_comb begin
      lim_raw = (scroll_rows == '0) ? 6'd1 : 6'(scroll_rows);
      if (lim_raw > 6'(ROWS)) begin
         lim_raw = 6'(ROWS);
      end
      lim = RW'(lim_raw);
   end

   assign tab_sum = {1'b0, col_ff} + (CW + 1)'(TAB_STEP);

   always_comb begin
      state_in    = state_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      cmd_in      = cmd_ff;
      code_in     = code_ff;
      idx_in      = idx_ff;
      in_range_in = in_range_ff;
      ptr_in      = ptr_ff;
      end_in      = end_ff;
      pend_in     = pend_ff;
      at_in       = at_ff;
      wr_en       = 1'b0;
      wr_addr     = AW'(ptr_ff);
      wr_data     = {attr, CH_SPACE};
      rd_en       = 1'b0;
      rd_addr     = AW'(ptr_ff);
      res_valid   = 1'b0;

      unique case (state_ff)
         ST_INIT: begin
            wr_en   = 1'b1;
            wr_data = {RESET_ATTR, CH_SPACE};
            ptr_in  = ptr_ff + 1'b1;
            if (ptr_ff == PW'(CELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_if.valid) begin
               cmd_in      = cmd_type'(req_if.cmd);
               code_in     = req_if.char_code;
               idx_in      = req_if.cell_index;
               in_range_in = RANGE_W'(req_if.cell_index) < RANGE_W'(CELLS);
               unique case (cmd_type'(req_if.cmd))
                  CMD_PUT: state_in = ST_CHECK;
                  CMD_CLEAR: begin
                     ptr_in   = '0;
                     end_in   = PW'(CELLS);
                     state_in = ST_FILL;
                  end
                  CMD_READ: state_in = ST_READ;
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_CHECK: begin
            if (row_ff >= lim) begin
               row_in  = lim - 1'b1;
               end_in  = PW'(lim) * PW'(COLUMNS);
               pend_in = 1'b0;
               if (lim == RW'(1)) begin
                  ptr_in   = '0;
                  state_in = ST_FILL;
               end else begin
                  ptr_in   = PW'(COLUMNS);
                  state_in = ST_COPY;
               end
            end else begin
               state_in = ST_ADDR;
            end
         end
         ST_COPY: begin
            // write back the cell read last cycle one row higher
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = AW'(ptr_ff - PW'(COLUMNS + 1));
               wr_data = rd_data;
            end
            if (ptr_ff != end_ff) begin
               rd_en   = 1'b1;
               rd_addr = AW'(ptr_ff);
               ptr_in  = ptr_ff + 1'b1;
               pend_in = 1'b1;
            end else begin
               pend_in  = 1'b0;
               ptr_in   = end_ff - PW'(COLUMNS);
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            wr_en  = 1'b1;
            ptr_in = ptr_ff + 1'b1;
            if (ptr_ff == end_ff - 1'b1) begin
               if (cmd_ff == CMD_CLEAR) begin
                  row_in   = '0;
                  col_in   = '0;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_ADDR;
               end
            end
         end
         ST_ADDR: begin
            at_in    = AW'(PW'(row_ff) * PW'(COLUMNS) + PW'(col_ff));
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_DONE;
            unique case (code_ff) inside
               [CH_SPACE:CH_TILDE]: begin
                  wr_en   = 1'b1;
                  wr_addr = at_ff;
                  wr_data = {attr, code_ff};
                  if (col_ff == CW'(COLUMNS - 1)) begin
                     col_in = '0;
                     row_in = row_ff + 1'b1;
                  end else begin
                     col_in = col_ff + 1'b1;
                  end
               end
               CH_BS: begin
                  if (col_ff != '0) begin
                     col_in   = col_ff - 1'b1;
                     at_in    = at_ff - 1'b1;
                     rd_en    = 1'b1;
                     rd_addr  = at_ff - 1'b1;
                     state_in = ST_BS;
                  end else if (row_ff != '0) begin
                     col_in = CW'(COLUMNS - 1);
                     row_in = row_ff - 1'b1;
                  end
               end
               CH_TAB: begin
                  if (tab_sum >= (CW + 1)'(COLUMNS)) begin
                     col_in = '0;
                     row_in = row_ff + 1'b1;
                  end else begin
                     col_in = tab_sum[CW-1:0];
                  end
               end
               CH_CR: col_in = '0;
               CH_LF: begin
                  col_in = '0;
                  row_in = row_ff + 1'b1;
               end
               default: ;
            endcase
         end
         ST_BS: begin
            // keep the old attribute, blank the character
            wr_en    = 1'b1;
            wr_addr  = at_ff;
            wr_data  = {rd_data[CELL_W-1:CHAR_W], CH_SPACE};
            state_in = ST_DONE;
         end
         ST_READ: begin
            if (in_range_ff) begin
               rd_en   = 1'b1;
               rd_addr = AW'(idx_ff);
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            res_valid = 1'b1;
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // shown row is one below the cursor row except on or below the last row
   always_comb begin
      shown = (row_ff < RW'(ROWS - 1)) ? row_ff + 1'b1 : row_ff;
      pos   = PW'(shown) * PW'(COLUMNS) + PW'(col_ff);
      res.cursor_position = CURSOR_W'(pos);
      if (cmd_ff == CMD_READ && in_range_ff) begin
         res.read_char = rd_data[CHAR_W-1:0];
         res.read_attr = rd_data[CELL_W-1:CHAR_W];
      end else begin
         res.read_char = '0;
         res.read_attr = '0;
      end
   end

   assign req_if.ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         row_ff   <= '0;
         col_ff   <= '0;
         ptr_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         ptr_ff   <= ptr_in;
         pend_ff  <= pend_in;
      end
      cmd_ff      <= cmd_in;
      code_ff     <= code_in;
      idx_ff      <= idx_in;
      in_range_ff <= in_range_in;
      end_ff      <= end_in;
      at_ff       <= at_in;
   end

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: text console writer testbench
// Drives put-character, clear, read and unused requests into the console,
// keeps its own model of the character store, cursor and registers, and
// compares every response field by field with the predicted report.
// Directed requests cover the character classes, cursor edges and scrolling
// corners; random phases then run under several scroll regions, attributes
// and idling patterns on both channels.
// ----------------------------------------------------------------------------
module tb_top;
   import tcw_pkg::*;

   localparam int COLS          = 80;
   localparam int ROW_COUNT     = 25;
   localparam int CELL_COUNT    = COLS * ROW_COUNT;
   localparam int INDEX_TOP     = (1 << INDEX_W) - 1;
   localparam int CYCLE_LIMIT   = 12_000_000;
   localparam int SETTLE_CYCLES = 50;
   localparam int PRINT_CAP     = 40;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset;

   tcw_req_if req_bus ();
   tcw_rsp_if rsp_bus ();
   tcw_csr_if csr_bus ();

   text_console_writer uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   always #5 clock = ~clock;

   // console model
   logic [CELL_W-1:0]   screen_cells [0:CELL_COUNT-1];
   logic [6:0]          cursor_col;
   logic [4:0]          cursor_row;
   logic [ATTR_W-1:0]   current_attr;
   logic [SCROLL_W-1:0] scroll_setting;

   rsp_type expected_reports [$];
   rsp_type oldest_report;

   int send_idle_pct;
   int rsp_idle_pct;
   int mismatch_count;
   int requests_sent;
   int reports_checked;
   int scroll_count;
   int clear_count;
   int read_count;
   int cycle_count;

   function automatic int region_rows();
      int lim;
      lim = scroll_setting;
      if (lim == 0) lim = 1;
      if (lim > ROW_COUNT) lim = ROW_COUNT;
      return lim;
   endfunction

   function automatic logic [CELL_W-1:0] blank_cell();
      return {current_attr, CH_SPACE};
   endfunction

   task automatic console_reset();
      for (int i = 0; i < CELL_COUNT; i++) screen_cells[i] = {RESET_ATTR, CH_SPACE};
      cursor_col     = '0;
      cursor_row     = '0;
      current_attr   = RESET_ATTR;
      scroll_setting = RESET_SCROLL;
   endtask

   task automatic console_clear();
      for (int i = 0; i < CELL_COUNT; i++) screen_cells[i] = blank_cell();
      cursor_col = '0;
      cursor_row = '0;
      clear_count++;
   endtask

   task automatic console_put(input logic [CHAR_W-1:0] code);
      int lim;
      int at;
      lim = region_rows();
      if (cursor_row >= lim) begin
         for (int i = COLS; i < lim * COLS; i++) screen_cells[i - COLS] = screen_cells[i];
         for (int i = (lim - 1) * COLS; i < lim * COLS; i++) screen_cells[i] = blank_cell();
         cursor_row = 5'(lim - 1);
         scroll_count++;
      end
      at = cursor_row * COLS + cursor_col;
      if (code >= CH_SPACE && code <= CH_TILDE) begin
         if (at < CELL_COUNT) screen_cells[at] = {current_attr, code};
         cursor_col = cursor_col + 7'd1;
         if (cursor_col >= COLS) begin
            cursor_col = '0;
            cursor_row = cursor_row + 5'd1;
         end
      end else if (code == CH_BS) begin
         if (cursor_col > 0) begin
            cursor_col = cursor_col - 7'd1;
            at = at - 1;
            if (at < CELL_COUNT) screen_cells[at] = {screen_cells[at][CELL_W-1:CHAR_W], CH_SPACE};
         end else if (cursor_row > 0) begin
            cursor_col = 7'(COLS - 1);
            cursor_row = cursor_row - 5'd1;
         end
      end else if (code == CH_TAB) begin
         cursor_col = cursor_col + 7'(TAB_STEP);
         if (cursor_col >= COLS) begin
            cursor_col = '0;
            cursor_row = cursor_row + 5'd1;
         end
      end else if (code == CH_CR) begin
         cursor_col = '0;
      end else if (code == CH_LF) begin
         cursor_col = '0;
         cursor_row = cursor_row + 5'd1;
      end
   endtask

   task automatic predict_console_step(input logic [CMD_W-1:0] cmd,
                                       input logic [CHAR_W-1:0] code,
                                       input logic [INDEX_W-1:0] idx,
                                       output rsp_type report);
      int shown;
      report = '0;
      case (cmd)
         CMD_PUT:   console_put(code);
         CMD_CLEAR: console_clear();
         CMD_READ: begin
            read_count++;
            if (idx < CELL_COUNT) begin
               report.read_char = screen_cells[idx][CHAR_W-1:0];
               report.read_attr = screen_cells[idx][CELL_W-1:CHAR_W];
            end
         end
         default: ;
      endcase
      shown = (cursor_row < ROW_COUNT - 1) ? cursor_row + 1 : cursor_row;
      report.cursor_position = CURSOR_W'(shown * COLS + cursor_col);
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP)
         $display("mismatch at response %0d: %s got 0x%0h want 0x%0h",
                  reports_checked, what, got, want);
   endtask

   // response checking and receiver stalls
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_reports.size() == 0) begin
            report_mismatch("response with nothing outstanding", rsp_bus.cursor_position, 0);
         end else begin
            oldest_report = expected_reports.pop_front();
            if (rsp_bus.cursor_position !== oldest_report.cursor_position)
               report_mismatch("cursor_position", rsp_bus.cursor_position,
                               oldest_report.cursor_position);
            if (rsp_bus.read_char !== oldest_report.read_char)
               report_mismatch("read_char", rsp_bus.read_char, oldest_report.read_char);
            if (rsp_bus.read_attr !== oldest_report.read_attr)
               report_mismatch("read_attr", rsp_bus.read_attr, oldest_report.read_attr);
         end
         reports_checked++;
      end
      rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d responses outstanding",
                  cycle_count, expected_reports.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic send_request(input logic [CMD_W-1:0] cmd,
                               input logic [CHAR_W-1:0] code,
                               input logic [INDEX_W-1:0] idx);
      rsp_type report;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.cmd        <= cmd;
      req_bus.char_code  <= code;
      req_bus.cell_index <= idx;
      do @(posedge clock); while (!req_bus.ready);
      predict_console_step(cmd, code, idx, report);
      expected_reports.push_back(report);
      requests_sent++;
   endtask

   task automatic drain_responses();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (expected_reports.size() != 0);
   endtask

   task automatic write_register(input reg_index_type index, input logic [CSR_DATA_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      if (index == REG_ATTRIBUTE) current_attr = data;
      else scroll_setting = data[SCROLL_W-1:0];
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_idling(input int sender_pct, input int receiver_pct);
      send_idle_pct = sender_pct;
      rsp_idle_pct  = receiver_pct;
   endtask

   task automatic send_random_request(input int lf_pct);
      int roll;
      int pick;
      logic [CMD_W-1:0]   cmd;
      logic [CHAR_W-1:0]  code;
      logic [INDEX_W-1:0] idx;
      code = CHAR_W'($urandom_range(0, 255));
      idx  = INDEX_W'($urandom_range(0, INDEX_TOP));
      roll = $urandom_range(0, 99);
      pick = $urandom_range(0, 99);
      if (roll < 1) begin
         cmd = CMD_CLEAR;
      end else if (roll < 2) begin
         cmd = CMD_UNUSED;
      end else if (roll < 14) begin
         cmd = CMD_READ;
         if (pick < 70) idx = INDEX_W'($urandom_range(0, region_rows() * COLS - 1));
         else if (pick < 90) idx = INDEX_W'($urandom_range(0, CELL_COUNT - 1));
         else idx = INDEX_W'($urandom_range(CELL_COUNT, INDEX_TOP));
      end else begin
         cmd = CMD_PUT;
         if (pick < lf_pct) code = CH_LF;
         else if (pick < lf_pct + 5) code = CH_BS;
         else if (pick < lf_pct + 9) code = CH_TAB;
         else if (pick < lf_pct + 12) code = CH_CR;
         else if (pick < lf_pct + 17)
            code = $urandom_range(0, 1) ? CHAR_W'($urandom_range(0, 8'h1F))
                                        : CHAR_W'($urandom_range(8'h7F, 8'hFF));
         else code = CHAR_W'($urandom_range(CH_SPACE, CH_TILDE));
      end
      send_request(cmd, code, idx);
   endtask

   // reset contents, out of range read and the unused command
   task automatic test_reset_state();
      send_request(CMD_READ, 8'h00, 11'd0);
      send_request(CMD_READ, 8'hFF, 11'(CELL_COUNT - 1));
      send_request(CMD_READ, 8'h00, 11'(INDEX_TOP));
      send_request(CMD_UNUSED, 8'h00, 11'd0);
   endtask

   // printable limits, ignored codes and cursor controls at the edges
   task automatic test_character_handling();
      send_request(CMD_PUT, CH_SPACE, 11'd0);
      send_request(CMD_PUT, CH_TILDE, 11'd0);
      send_request(CMD_PUT, 8'h1F, 11'd0);
      send_request(CMD_PUT, 8'h7F, 11'd0);
      send_request(CMD_PUT, 8'hFF, 11'(INDEX_TOP));
      send_request(CMD_PUT, CH_BS, 11'd0);
      send_request(CMD_READ, 8'h00, 11'd1);
      send_request(CMD_PUT, CH_TAB, 11'd0);
      send_request(CMD_PUT, CH_CR, 11'd0);
      send_request(CMD_PUT, CH_BS, 11'd0);
      send_request(CMD_PUT, CH_LF, 11'd0);
      send_request(CMD_PUT, CH_BS, 11'd0);
      send_request(CMD_PUT, 8'h41, 11'd0);
      send_request(CMD_READ, 8'h00, 11'(COLS - 1));
      drain_responses();
   endtask

   // zero scroll limit behaves as one row, then clear with a new attribute
   task automatic test_scroll_and_clear();
      write_register(REG_ATTRIBUTE, 8'hFF);
      write_register(REG_SCROLL_ROWS, 8'hE0);
      send_request(CMD_PUT, 8'h5A, 11'd0);
      send_request(CMD_READ, 8'h00, 11'd0);
      send_request(CMD_READ, 8'h00, 11'(COLS));
      send_request(CMD_CLEAR, 8'h00, 11'd0);
      send_request(CMD_READ, 8'h00, 11'(CELL_COUNT - 1));
      drain_responses();
   endtask

   task automatic test_random_traffic(input int item_count, input logic [ATTR_W-1:0] attr,
                                      input logic [CSR_DATA_W-1:0] scroll, input int lf_pct);
      write_register(REG_ATTRIBUTE, attr);
      write_register(REG_SCROLL_ROWS, scroll);
      for (int n = 0; n < item_count; n++) begin
         // hold off once so the pipeline empties mid stream
         if (n == item_count / 2) drain_responses();
         send_random_request(lf_pct);
      end
      drain_responses();
   endtask

   initial begin
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.cmd        <= CMD_PUT;
      req_bus.char_code  <= '0;
      req_bus.cell_index <= '0;
      csr_bus.valid      <= 1'b0;
      csr_bus.index      <= REG_ATTRIBUTE;
      csr_bus.data       <= '0;
      mismatch_count  = 0;
      requests_sent   = 0;
      reports_checked = 0;
      scroll_count    = 0;
      clear_count     = 0;
      read_count      = 0;
      cycle_count     = 0;
      console_reset();
      set_idling(36, 56);
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_character_handling();
      test_scroll_and_clear();
      test_random_traffic(350, 8'($urandom_range(0, 255)), 8'h04, 8);
      test_random_traffic(250, 8'h00, 8'h0C, 8);
      set_idling(56, 36);
      test_random_traffic(300, 8'($urandom_range(0, 255)), 8'h21, 8);
      test_random_traffic(200, 8'($urandom_range(0, 255)), 8'h19, 15);
      set_idling(0, 0);
      test_random_traffic(150, 8'hFF, 8'hFF, 15);
      test_random_traffic(150, 8'($urandom_range(0, 255)), 8'h02, 8);

      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d requests and %0d responses: %0d reads, %0d scrolls, %0d clears",
               requests_sent, reports_checked, read_count, scroll_count, clear_count);
      $display("scroll regions of one to full height, attributes at both extremes, %0d cycles",
               cycle_count);
      if (mismatch_count == 0 && expected_reports.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
